// File: rtl/lse_pkg.sv
package lse_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // Register index of the mode register, taken from the word address bit, paddr[2].
  localparam logic REG_MODE = 1'b0;

  // Mode codes.
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Terminator length and the run length that flags the end of a hidden text.
  localparam logic [3:0] TERM_LEN   = 4'd8;
  localparam logic [3:0] RUN_TARGET = 4'd8;

  // Characters of the terminator and of its set.
  localparam logic [7:0] CH_EQ = 8'h3D;  // '='
  localparam logic [7:0] CH_LT = 8'h3C;  // '<'
  localparam logic [7:0] CH_E  = 8'h45;  // 'E'
  localparam logic [7:0] CH_N  = 8'h4E;  // 'N'
  localparam logic [7:0] CH_D  = 8'h44;  // 'D'
  localparam logic [7:0] CH_EX = 8'h21;  // '!'
  localparam logic [7:0] CH_GT = 8'h3E;  // '>'

  typedef struct packed {
    logic [7:0] cover0;
    logic [7:0] cover1;
    logic [7:0] cover2;
    logic [7:0] cover3;
    logic [7:0] cover4;
    logic [7:0] cover5;
    logic [7:0] cover6;
    logic [7:0] cover7;
    logic [7:0] message_byte;
    logic       message_last;
  } lse_in_t;

  typedef struct packed {
    logic [7:0] stego0;
    logic [7:0] stego1;
    logic [7:0] stego2;
    logic [7:0] stego3;
    logic [7:0] stego4;
    logic [7:0] stego5;
    logic [7:0] stego6;
    logic [7:0] stego7;
    logic [7:0] recovered_byte;
    logic       end_found;
    logic       terminator_done;
  } lse_out_t;

  // Terminator character at a given position, "=<END!>=".
  function automatic logic [7:0] term_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_EQ;
      3'd1:    ch = CH_LT;
      3'd2:    ch = CH_E;
      3'd3:    ch = CH_N;
      3'd4:    ch = CH_D;
      3'd5:    ch = CH_EX;
      3'd6:    ch = CH_GT;
      default: ch = CH_EQ;
    endcase
    return ch;
  endfunction

  // True when a byte belongs to the terminator character set.
  function automatic logic in_marker_set(input logic [7:0] b);
    return (b == CH_EQ) || (b == CH_LT) || (b == CH_E) || (b == CH_N) ||
           (b == CH_D) || (b == CH_EX) || (b == CH_GT);
  endfunction

endpackage

// File: rtl/lse_if.sv
// Input channel: cover bytes plus the message byte to hide.
interface lse_in_if;
  import lse_pkg::*;

  logic    valid;
  logic    ready;
  lse_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel: stego bytes plus the recovered byte and the extract and embed status.
interface lse_out_if;
  import lse_pkg::*;

  logic     valid;
  logic     ready;
  lse_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lsb_stego_embed_extract.sv
// LSB steganography embed and extract. Every input item carries eight cover
// bytes and one message byte; one result item comes back for each, passing
// through the input register and then the result register, and the block takes
// one item per clock as long as results are taken. The loop through the
// terminator phase and marker run counters is what sets that rate. In embed
// mode (mode register 0) each cover LSB takes one message bit, MSB in cover0; after
// an item flagged message_last the next eight embed items carry "=<END!>=" and the
// eighth raises terminator_done. In extract mode the cover LSBs are packed into
// recovered_byte, and end_found rises on the eighth consecutive byte from the set
// = < E N D ! > , after which the run starts over. Change the mode only while no
// item is in flight; a mode change keeps both counters.
module lsb_stego_embed_extract (
  input  logic                          clk,
  input  logic                          rst_n,
  lse_in_if.sink                        in_ch,
  lse_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lse_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lse_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lse_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import lse_pkg::*;

  logic       mode_r;
  logic [3:0] term_phase_r, term_phase_nxt;
  logic [3:0] marker_run_r, marker_run_nxt;

  logic       s1_valid_r;
  lse_in_t    s1_data_r;
  logic       s1_move;

  logic       out_valid_r;
  lse_out_t   out_data_r, out_data_nxt;

  logic [7:0] cover_lsbs;
  logic [7:0] embed_data;
  logic       term_pending;
  logic [3:0] phase_m1;
  logic [3:0] run_inc;

  // Configuration port: zero wait states, register chosen by the word address.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {{(CFG_DATA_W-1){1'b0}}, mode_r}
                                         : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EMBED;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  // Handshake: the input register advances when the result register is free.
  assign s1_move      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_move;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
  end

  // Message bit source and packed cover LSBs.
  assign cover_lsbs   = {s1_data_r.cover0[0], s1_data_r.cover1[0], s1_data_r.cover2[0],
                         s1_data_r.cover3[0], s1_data_r.cover4[0], s1_data_r.cover5[0],
                         s1_data_r.cover6[0], s1_data_r.cover7[0]};
  assign term_pending = (term_phase_r != 4'd0) && (term_phase_r <= TERM_LEN);
  assign phase_m1     = term_phase_r - 4'd1;
  assign embed_data   = term_pending ? term_char(phase_m1[2:0]) : s1_data_r.message_byte;
  assign run_inc      = marker_run_r + 4'd1;

  // Result and counter update for the item in the input register.
  always_comb begin
    term_phase_nxt = term_phase_r;
    marker_run_nxt = marker_run_r;
    out_data_nxt   = '0;
    if (mode_r == MODE_EMBED) begin
      out_data_nxt.stego0 = {s1_data_r.cover0[7:1], embed_data[7]};
      out_data_nxt.stego1 = {s1_data_r.cover1[7:1], embed_data[6]};
      out_data_nxt.stego2 = {s1_data_r.cover2[7:1], embed_data[5]};
      out_data_nxt.stego3 = {s1_data_r.cover3[7:1], embed_data[4]};
      out_data_nxt.stego4 = {s1_data_r.cover4[7:1], embed_data[3]};
      out_data_nxt.stego5 = {s1_data_r.cover5[7:1], embed_data[2]};
      out_data_nxt.stego6 = {s1_data_r.cover6[7:1], embed_data[1]};
      out_data_nxt.stego7 = {s1_data_r.cover7[7:1], embed_data[0]};
      if (term_pending) begin
        if (term_phase_r == TERM_LEN) begin
          out_data_nxt.terminator_done = 1'b1;
          term_phase_nxt = 4'd0;
        end else begin
          term_phase_nxt = term_phase_r + 4'd1;
        end
      end else begin
        term_phase_nxt = {3'b000, s1_data_r.message_last};
      end
    end else begin
      out_data_nxt.stego0         = s1_data_r.cover0;
      out_data_nxt.stego1         = s1_data_r.cover1;
      out_data_nxt.stego2         = s1_data_r.cover2;
      out_data_nxt.stego3         = s1_data_r.cover3;
      out_data_nxt.stego4         = s1_data_r.cover4;
      out_data_nxt.stego5         = s1_data_r.cover5;
      out_data_nxt.stego6         = s1_data_r.cover6;
      out_data_nxt.stego7         = s1_data_r.cover7;
      out_data_nxt.recovered_byte = cover_lsbs;
      if (in_marker_set(cover_lsbs)) begin
        if (run_inc >= RUN_TARGET) begin
          out_data_nxt.end_found = 1'b1;
          marker_run_nxt = 4'd0;
        end else begin
          marker_run_nxt = run_inc;
        end
      end else begin
        marker_run_nxt = 4'd0;
      end
    end
  end

  // Counters advance once per item, as it moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_phase_r <= 4'd0;
      marker_run_r <= 4'd0;
    end else if (s1_move) begin
      term_phase_r <= term_phase_nxt;
      marker_run_r <= marker_run_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The terminator phase never leaves its range of none pending or one to eight.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    term_phase_r <= TERM_LEN)
    else $error("terminator phase out of range");

  // The marker run restarts on reaching its target, so it stays below it.
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    marker_run_r < RUN_TARGET)
    else $error("marker run reached its target without restarting");

  // Embed and extract status never appear together on one item.
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.end_found && out_data_r.terminator_done))
    else $error("end_found and terminator_done both set");

  // A finished terminator leaves no terminator pending.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && out_data_nxt.terminator_done) |=> (term_phase_r == 4'd0))
    else $error("terminator phase not cleared after the last character");

endmodule

// File: tb/tb_lsb_stego_embed_extract.sv
module tb_lsb_stego_embed_extract;
  timeunit 1ns;
  timeprecision 1ps;

  import lse_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = '0;

  // The terminator string "=<END!>=", first character in the top byte.
  localparam logic [63:0] TERM_STR = {CH_EQ, CH_LT, CH_E, CH_N, CH_D, CH_EX, CH_GT, CH_EQ};

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  lse_in_if in_ch ();
  lse_out_if out_ch ();

  lsb_stego_embed_extract uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted block state and the results still owed by the block.
  logic       cur_mode;
  logic [3:0] term_pos;
  logic [3:0] marker_count;
  lse_out_t   stego_expected[$];

  // Stimulus planning state.
  logic [7:0] hidden_plan[$];
  int         msg_left = 0;

  // Idling controls shared by the sender, the receiver and the tests.
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int hold_req = 0;

  int err_count = 0;
  int n_embed = 0;
  int n_extract = 0;
  int n_term_done = 0;
  int n_end_found = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] term_byte(int k);
    return TERM_STR[63 - 8 * k -: 8];
  endfunction

  function automatic bit is_term_char(logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (b == term_byte(k)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Work out the result for one accepted item and advance the predicted counters.
  function automatic lse_out_t predict_stego(lse_in_t it);
    lse_out_t   r;
    logic [7:0] hid;
    logic [63:0] cov;
    r = '0;
    cov = {it.cover0, it.cover1, it.cover2, it.cover3,
           it.cover4, it.cover5, it.cover6, it.cover7};
    if (cur_mode == MODE_EMBED) begin
      n_embed++;
      if (term_pos >= 4'd1 && term_pos <= TERM_LEN) begin
        hid = term_byte(int'(term_pos) - 1);
        if (term_pos == TERM_LEN) begin
          r.terminator_done = 1'b1;
          term_pos = 4'd0;
        end else begin
          term_pos = term_pos + 4'd1;
        end
      end else begin
        hid = it.message_byte;
        term_pos = it.message_last ? 4'd1 : 4'd0;
      end
      for (int i = 0; i < 8; i++) cov[56 - 8 * i] = hid[7 - i];
      {r.stego0, r.stego1, r.stego2, r.stego3,
       r.stego4, r.stego5, r.stego6, r.stego7} = cov;
    end else begin
      n_extract++;
      for (int i = 0; i < 8; i++) hid[7 - i] = cov[56 - 8 * i];
      {r.stego0, r.stego1, r.stego2, r.stego3,
       r.stego4, r.stego5, r.stego6, r.stego7} = cov;
      r.recovered_byte = hid;
      if (is_term_char(hid)) begin
        marker_count = marker_count + 4'd1;
        if (marker_count >= RUN_TARGET) begin
          r.end_found = 1'b1;
          marker_count = 4'd0;
        end
      end else begin
        marker_count = 4'd0;
      end
    end
    return r;
  endfunction

  function automatic lse_in_t rand_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return lse_in_t'(raw[$bits(lse_in_t)-1:0]);
  endfunction

  // Random cover bytes whose LSBs spell the given hidden byte.
  function automatic lse_in_t hide_byte(logic [7:0] b);
    lse_in_t     it;
    logic [63:0] cov;
    it = rand_item();
    cov = {it.cover0, it.cover1, it.cover2, it.cover3,
           it.cover4, it.cover5, it.cover6, it.cover7};
    for (int i = 0; i < 8; i++) cov[56 - 8 * i] = b[7 - i];
    {it.cover0, it.cover1, it.cover2, it.cover3,
     it.cover4, it.cover5, it.cover6, it.cover7} = cov;
    return it;
  endfunction

  function automatic lse_in_t covers_of(logic [7:0] v, logic [7:0] msg, logic last);
    lse_in_t it;
    it = '0;
    {it.cover0, it.cover1, it.cover2, it.cover3,
     it.cover4, it.cover5, it.cover6, it.cover7} = {8{v}};
    it.message_byte = msg;
    it.message_last = last;
    return it;
  endfunction

  // Next hidden byte for extract traffic: terminators, marker runs, text and noise.
  function automatic logic [7:0] next_hidden();
    int len;
    if (hidden_plan.size() == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int k = 0; k < 8; k++) hidden_plan.push_back(term_byte(k));
        end
        4, 5: begin
          len = $urandom_range(5, 12);
          for (int k = 0; k < len; k++) hidden_plan.push_back(term_byte($urandom_range(0, 6)));
        end
        6, 7: begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) hidden_plan.push_back(8'($urandom_range(32, 126)));
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) hidden_plan.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    return hidden_plan.pop_front();
  endfunction

  // Next embed item: mostly whole messages closed by a last flag, some noise.
  function automatic lse_in_t next_embed_item();
    lse_in_t it;
    it = rand_item();
    if (term_pos == 4'd0 && $urandom_range(0, 9) != 0) begin
      if (msg_left == 0) msg_left = $urandom_range(1, 10);
      it.message_last = (msg_left == 1);
      msg_left--;
    end
    return it;
  endfunction

  task automatic send_item(lse_in_t it);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.data = it;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    stego_expected.push_back(predict_stego(it));
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (stego_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [CFG_ADDR_W-1:0] addr,
                            logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Mode changes only with nothing in flight; read the register back afterwards.
  task automatic set_mode(logic m);
    logic [CFG_DATA_W-1:0] rd;
    drain();
    cfg_access(1'b1, MODE_ADDR, CFG_DATA_W'(m), rd);
    cur_mode = m;
    cfg_access(1'b0, MODE_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(m)) begin
      $error("mode readback: expected %0h, actual %0h", m, rd);
      err_count++;
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        out_ch.ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    lse_out_t want;
    lse_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (stego_expected.size() == 0) begin
        $error("result item arrived with no prediction waiting");
        err_count++;
      end else begin
        want = stego_expected.pop_front();
        check_field("stego0", want.stego0, got.stego0);
        check_field("stego1", want.stego1, got.stego1);
        check_field("stego2", want.stego2, got.stego2);
        check_field("stego3", want.stego3, got.stego3);
        check_field("stego4", want.stego4, got.stego4);
        check_field("stego5", want.stego5, got.stego5);
        check_field("stego6", want.stego6, got.stego6);
        check_field("stego7", want.stego7, got.stego7);
        check_field("recovered_byte", want.recovered_byte, got.recovered_byte);
        check_field("end_found", 8'(want.end_found), 8'(got.end_found));
        check_field("terminator_done", 8'(want.terminator_done), 8'(got.terminator_done));
      end
      if (got.end_found === 1'b1) n_end_found++;
      if (got.terminator_done === 1'b1) n_term_done++;
    end
  end

  // Embed extremes, a last flag, and the start of a terminator left pending.
  task automatic test_embed_directed();
    lse_in_t it;
    set_mode(MODE_EMBED);
    send_item(covers_of(8'h00, 8'hFF, 1'b0));
    send_item(covers_of(8'hFF, 8'h00, 1'b0));
    it = rand_item();
    it.message_byte = 8'hA5;
    it.message_last = 1'b1;
    send_item(it);
    // A last flag during the terminator must be ignored.
    it = rand_item();
    it.message_last = 1'b1;
    send_item(it);
    it.message_last = 1'b0;
    send_item(it);
    send_item(rand_item());
  endtask

  // Extract a broken run, then a full terminator that must raise end_found.
  task automatic test_extract_directed();
    set_mode(MODE_EXTRACT);
    send_item(covers_of(8'h00, 8'h00, 1'b1));
    for (int k = 0; k < 5; k++) send_item(hide_byte(term_byte(k)));
    send_item(hide_byte(8'h78));
    for (int k = 0; k < 8; k++) send_item(hide_byte(term_byte(k)));
  endtask

  // Back in embed mode the pending terminator resumes where it stopped.
  task automatic test_embed_resume();
    lse_in_t it;
    set_mode(MODE_EMBED);
    for (int k = 0; k < 5; k++) send_item(rand_item());
    it = rand_item();
    it.message_last = 1'b0;
    send_item(it);
  endtask

  // Alternating random phases of embed messages and extract streams.
  task automatic test_random_mix();
    logic m;
    m = 1'($urandom_range(0, 1));
    for (int ph = 0; ph < 10; ph++) begin
      m = ~m;
      set_mode(m);
      for (int n = 0; n < 65; n++) begin
        if (m == MODE_EMBED) send_item(next_embed_item());
        else send_item(hide_byte(next_hidden()));
      end
    end
  endtask

  // Hold the output long enough to fill the block, then let it drain.
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_req = 80;
    for (int n = 0; n < 40; n++) begin
      if (cur_mode == MODE_EMBED) send_item(next_embed_item());
      else send_item(hide_byte(next_hidden()));
    end
    drain();
    src_idle_en = 1'b1;
  endtask

  // Full rate on both sides to finish.
  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    set_mode(MODE_EMBED);
    for (int n = 0; n < 40; n++) send_item(next_embed_item());
    set_mode(MODE_EXTRACT);
    for (int n = 0; n < 40; n++) send_item(hide_byte(next_hidden()));
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cur_mode = MODE_EMBED;
    term_pos = 4'd0;
    marker_count = 4'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_embed_directed();
    test_extract_directed();
    test_embed_resume();
    test_random_mix();
    test_backpressure();
    test_full_rate();
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d embed and %0d extract items across mode switches and stalls.",
             n_embed, n_extract);
    $display("Saw %0d embedded terminators and %0d detected end markers.",
             n_term_done, n_end_found);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lse_pkg.sv
rtl/lse_if.sv
rtl/lsb_stego_embed_extract.sv
tb/tb_lsb_stego_embed_extract.sv
